// ===== src/rdpr_pkg.sv =====
// Shared types and constants of the remote debug packet receiver.
package rdpr_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int CNT_W = $clog2(BUFFER_BYTES);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [6:0] CH_DOLLAR = 7'h24;
	localparam logic [6:0] CH_HASH = 7'h23;
	localparam logic [6:0] CH_COLON = 7'h3A;
	localparam logic [6:0] CH_PLUS = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	typedef enum logic [2:0] {
		EV_PAYLOAD = 3'd0,
		EV_GOOD = 3'd1,
		EV_BAD = 3'd2,
		EV_RESTART = 3'd3,
		EV_OVERFLOW = 3'd4
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t kind;
		logic [6:0] chr;
		logic [11:0] count;
		logic [7:0] sum;
		logic [7:0] rx_sum;
		logic seq;
		logic [6:0] lead0;
		logic [6:0] lead1;
	} rdpr_event_t;

endpackage

// ===== src/rdpr_front.sv =====
// Parser: classifies one character per cycle into events if accept is high.
module rdpr_front import rdpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [6:0] rx_char,
	output logic ev_valid,
	output rdpr_event_t ev
);

	typedef enum logic [3:0] {
		MODE_HUNT = 4'b0001,
		MODE_DATA = 4'b0010,
		MODE_HEX1 = 4'b0100,
		MODE_HEX2 = 4'b1000
	} mode_t;

	mode_t mode_q, mode_d;
	logic [7:0] sum_q, sum_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0] high_q, high_d;
	logic [6:0] lead_q [3];
	logic [6:0] lead_d [3];

	function automatic logic [7:0] digit_value(input logic [6:0] c);
		logic [7:0] v;
		case (c) inside
			[7'h61:7'h66]: v = 8'(c - 7'h61) + 8'd10;
			[7'h30:7'h39]: v = 8'(c - 7'h30);
			[7'h41:7'h46]: v = 8'(c - 7'h41) + 8'd10;
			default: v = 8'hFF;
		endcase
		return v;
	endfunction

	logic [7:0] dv;
	logic [7:0] rx_sum;
	logic [7:0] add_sum;
	logic [CNT_W-1:0] inc_count;
	logic good;

	assign dv = digit_value(rx_char);
	assign rx_sum = high_q + dv;
	assign add_sum = sum_q + {1'b0, rx_char};
	assign inc_count = count_q + CNT_W'(1);
	assign good = (rx_sum == sum_q);

	always_comb begin
		mode_d = mode_q;
		sum_d = sum_q;
		count_d = count_q;
		high_d = high_q;
		lead_d = lead_q;
		ev_valid = 1'b0;
		ev = '0;
		ev.kind = EV_PAYLOAD;
		case (mode_q)
			MODE_HUNT: begin
				if (rx_char == CH_DOLLAR) begin
					sum_d = '0;
					count_d = '0;
					high_d = '0;
					lead_d = '{default: '0};
					mode_d = MODE_DATA;
				end
			end
			MODE_DATA: begin
				if (rx_char == CH_DOLLAR) begin
					sum_d = '0;
					count_d = '0;
					high_d = '0;
					lead_d = '{default: '0};
					ev_valid = 1'b1;
					ev.kind = EV_RESTART;
				end else if (rx_char == CH_HASH) begin
					mode_d = MODE_HEX1;
				end else begin
					sum_d = add_sum;
					count_d = inc_count;
					if (count_q < CNT_W'(3)) begin
						lead_d[count_q[1:0]] = rx_char;
					end
					ev_valid = 1'b1;
					if (count_q == CNT_W'(BUFFER_BYTES - 2)) begin
						ev.kind = EV_OVERFLOW;
						ev.count = 12'(inc_count);
						ev.sum = add_sum;
						mode_d = MODE_HUNT;
					end else begin
						ev.kind = EV_PAYLOAD;
						ev.chr = rx_char;
						ev.count = 12'(count_q);
					end
				end
			end
			MODE_HEX1: begin
				high_d = {dv[3:0], 4'h0};
				mode_d = MODE_HEX2;
			end
			MODE_HEX2: begin
				ev_valid = 1'b1;
				ev.kind = good ? EV_GOOD : EV_BAD;
				ev.count = 12'(count_q);
				ev.sum = sum_q;
				ev.rx_sum = rx_sum;
				ev.seq = good && (count_q >= CNT_W'(3)) && (lead_q[2] == CH_COLON);
				ev.lead0 = lead_q[0];
				ev.lead1 = lead_q[1];
				mode_d = MODE_HUNT;
			end
			default: begin
				mode_d = MODE_HUNT;
			end
		endcase
		if (!accept) begin
			ev_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			sum_q <= '0;
			count_q <= '0;
			high_q <= '0;
			lead_q <= '{default: '0};
		end else if (accept) begin
			mode_q <= mode_d;
			sum_q <= sum_d;
			count_q <= count_d;
			high_q <= high_d;
			lead_q <= lead_d;
		end
	end

endmodule

// ===== src/rdpr_queue.sv =====
// Short event queue between the parser and the result stage.
module rdpr_queue import rdpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input rdpr_event_t wr_data,
	output logic full,
	input logic rd_en,
	output logic nonempty,
	output rdpr_event_t rd_data
);

	rdpr_event_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] fill_q;

	assign full = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nonempty = (fill_q != '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10: fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01: fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== src/rdpr_back.sv =====
// Result stage: expands queued events into result fields and holds them for pop.
module rdpr_back import rdpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic ev_avail,
	input rdpr_event_t ev,
	output logic ev_take,
	input logic pop,
	output logic empty,
	output logic [2:0] event_kind,
	output logic [6:0] data_char,
	output logic [11:0] char_index,
	output logic [6:0] reply_char,
	output logic seq_present,
	output logic [6:0] seq_first,
	output logic [6:0] seq_second,
	output logic [11:0] payload_length,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum
);

	logic valid_q;
	logic [2:0] kind_q;
	logic [6:0] data_q;
	logic [11:0] index_q;
	logic [6:0] reply_q;
	logic seq_q;
	logic [6:0] seq1_q;
	logic [6:0] seq2_q;
	logic [11:0] length_q;
	logic [7:0] csum_q;
	logic [7:0] rsum_q;

	logic is_payload;
	logic is_verdict;
	logic has_length;

	assign ev_take = ev_avail && (!valid_q || pop);
	assign empty = !valid_q;

	assign is_payload = (ev.kind == EV_PAYLOAD);
	assign is_verdict = (ev.kind == EV_GOOD) || (ev.kind == EV_BAD);
	assign has_length = is_verdict || (ev.kind == EV_OVERFLOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ev_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_take) begin
			kind_q <= ev.kind;
			data_q <= is_payload ? ev.chr : '0;
			index_q <= is_payload ? ev.count : '0;
			case (ev.kind)
				EV_GOOD: reply_q <= CH_PLUS;
				EV_BAD: reply_q <= CH_MINUS;
				default: reply_q <= '0;
			endcase
			seq_q <= ev.seq;
			seq1_q <= ev.seq ? ev.lead0 : '0;
			seq2_q <= ev.seq ? ev.lead1 : '0;
			length_q <= has_length ? ev.count : '0;
			csum_q <= has_length ? ev.sum : '0;
			rsum_q <= is_verdict ? ev.rx_sum : '0;
		end
	end

	assign event_kind = kind_q;
	assign data_char = data_q;
	assign char_index = index_q;
	assign reply_char = reply_q;
	assign seq_present = seq_q;
	assign seq_first = seq1_q;
	assign seq_second = seq2_q;
	assign payload_length = length_q;
	assign computed_sum = csum_q;
	assign received_sum = rsum_q;

endmodule

// ===== src/remote_debug_packet_receiver_unit.sv =====
// Top level of the remote debug packet receiver: parser, event queue and result stage.
// One character per cycle is taken while full is low; the parser state updates in that cycle.
// A character's event is written into the event queue, then registered in the result stage.
// A four-entry event queue sits between parser and result stage; full rises only when it fills.
// Reset clears the parser to hunting for a start character and empties the queue and result stage.
module remote_debug_packet_receiver_unit import rdpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [6:0] rx_char,
	output logic empty,
	input logic pop,
	output logic [2:0] event_kind,
	output logic [6:0] data_char,
	output logic [11:0] char_index,
	output logic [6:0] reply_char,
	output logic seq_present,
	output logic [6:0] seq_first,
	output logic [6:0] seq_second,
	output logic [11:0] payload_length,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum
);

	logic accept;
	logic ev_valid;
	rdpr_event_t ev_front;
	logic q_nonempty;
	logic q_take;
	rdpr_event_t ev_queued;

	assign accept = push && !full;

	rdpr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_char(rx_char),
		.ev_valid(ev_valid),
		.ev(ev_front)
	);

	rdpr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(ev_valid),
		.wr_data(ev_front),
		.full(full),
		.rd_en(q_take),
		.nonempty(q_nonempty),
		.rd_data(ev_queued)
	);

	rdpr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ev_avail(q_nonempty),
		.ev(ev_queued),
		.ev_take(q_take),
		.pop(pop),
		.empty(empty),
		.event_kind(event_kind),
		.data_char(data_char),
		.char_index(char_index),
		.reply_char(reply_char),
		.seq_present(seq_present),
		.seq_first(seq_first),
		.seq_second(seq_second),
		.payload_length(payload_length),
		.computed_sum(computed_sum),
		.received_sum(received_sum)
	);

endmodule
